// ===== src/iosf_pkg.sv =====
// Shared types and constants of the IPv4 header option filter.
package iosf_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CountW = 6;
	localparam int unsigned CfgIdxW = 2;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_FIRST_SEC_TYPE = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SECOND_SEC_TYPE = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_FILTERED_PROTOCOL = 2'd2;

	// Register reset values
	localparam logic [ByteW-1:0] RST_FIRST_SEC_TYPE = 8'd130;
	localparam logic [ByteW-1:0] RST_SECOND_SEC_TYPE = 8'd133;
	localparam logic [ByteW-1:0] RST_FILTERED_PROTOCOL = 8'd6;

	// Header layout
	localparam logic [CountW-1:0] PROTOCOL_POS = 6'd9;
	localparam logic [CountW-1:0] OPTIONS_POS = 6'd20;
	localparam logic [CountW-1:0] COUNT_MAX = 6'd63;
	localparam logic [3:0] MIN_IHL = 4'd5;

	// Option type codes
	localparam logic [ByteW-1:0] OPT_END = 8'd0;
	localparam logic [ByteW-1:0] OPT_NOP = 8'd1;
	localparam logic [ByteW-1:0] OPT_MIN_LEN = 8'd2;

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_LEN = 2'd1,
		PH_SKIP = 2'd2
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] first_sec_type;
		logic [ByteW-1:0] second_sec_type;
		logic [ByteW-1:0] filtered_protocol;
	} cfg_t;

	typedef struct packed {
		logic drop;
		logic malformed;
		logic [ByteW-1:0] matched_type;
	} result_t;

endpackage

// ===== src/iosf_in_if.sv =====
// Input channel: one header byte per transfer with a start-of-packet mark.
interface iosf_in_if;
	logic valid;
	logic ready;
	logic [iosf_pkg::ByteW-1:0] hdr_byte;
	logic start_of_packet;

	modport source (output valid, output hdr_byte, output start_of_packet, input ready);
	modport sink (input valid, input hdr_byte, input start_of_packet, output ready);
endinterface

// ===== src/iosf_out_if.sv =====
// Output channel: one verdict per packet header.
interface iosf_out_if;
	logic valid;
	logic ready;
	logic drop;
	logic malformed;
	logic [iosf_pkg::ByteW-1:0] matched_type;

	modport source (output valid, output drop, output malformed, output matched_type, input ready);
	modport sink (input valid, input drop, input malformed, input matched_type, output ready);
endinterface

// ===== src/iosf_parser.sv =====
// Per-packet parse state and the single-byte option walk.
module iosf_parser (
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  logic [iosf_pkg::ByteW-1:0] hdr_byte,
	input  logic start_of_packet,
	input  iosf_pkg::cfg_t cfg,
	output logic res_valid,
	output iosf_pkg::result_t res
);

	logic [iosf_pkg::CountW-1:0] byte_count_q, byte_count_d;
	logic [iosf_pkg::CountW-1:0] header_bytes_q, header_bytes_d;
	logic protocol_hit_q, protocol_hit_d;
	iosf_pkg::phase_t phase_q, phase_d;
	logic [iosf_pkg::ByteW-1:0] skip_left_q, skip_left_d;
	logic found_q, found_d;
	logic stopped_q, stopped_d;
	logic bad_q, bad_d;
	logic [iosf_pkg::ByteW-1:0] found_type_q, found_type_d;
	logic verdict_done_q, verdict_done_d;

	logic [iosf_pkg::CountW:0] remaining;
	logic [iosf_pkg::ByteW-1:0] len_minus2;
	logic is_last;

	// Bytes left in the header after the current one
	assign remaining = {1'b0, header_bytes_q} - 7'd1 - {1'b0, byte_count_q};
	assign len_minus2 = hdr_byte - iosf_pkg::OPT_MIN_LEN;
	assign is_last = ({1'b0, byte_count_q} + 7'd1) >= {1'b0, header_bytes_q};

	// Work out the state after this byte and any verdict it causes
	always_comb begin
		byte_count_d = byte_count_q;
		header_bytes_d = header_bytes_q;
		protocol_hit_d = protocol_hit_q;
		phase_d = phase_q;
		skip_left_d = skip_left_q;
		found_d = found_q;
		stopped_d = stopped_q;
		bad_d = bad_q;
		found_type_d = found_type_q;
		verdict_done_d = verdict_done_q;
		res_valid = 1'b0;
		res = '0;

		if (start_of_packet) begin
			// Begin a new header, abandoning any unfinished one
			header_bytes_d = {hdr_byte[3:0], 2'b00};
			protocol_hit_d = 1'b0;
			phase_d = iosf_pkg::PH_TYPE;
			skip_left_d = '0;
			found_d = 1'b0;
			stopped_d = 1'b0;
			bad_d = 1'b0;
			found_type_d = '0;
			if (hdr_byte[3:0] < iosf_pkg::MIN_IHL) begin
				byte_count_d = '0;
				verdict_done_d = 1'b1;
				res_valid = 1'b1;
				res.malformed = 1'b1;
			end else begin
				byte_count_d = 6'd1;
				verdict_done_d = 1'b0;
			end
		end else if (!verdict_done_q) begin
			if (byte_count_q == iosf_pkg::PROTOCOL_POS) begin
				protocol_hit_d = (hdr_byte == cfg.filtered_protocol);
			end

			// Walk the options
			if (byte_count_q >= iosf_pkg::OPTIONS_POS && protocol_hit_q && !stopped_q) begin
				case (phase_q)
					iosf_pkg::PH_TYPE: begin
						if (hdr_byte == iosf_pkg::OPT_END) begin
							stopped_d = 1'b1;
						end else if (hdr_byte != iosf_pkg::OPT_NOP) begin
							if ((hdr_byte == cfg.first_sec_type ||
									hdr_byte == cfg.second_sec_type) && !found_q) begin
								found_d = 1'b1;
								found_type_d = hdr_byte;
							end
							phase_d = iosf_pkg::PH_LEN;
						end
					end
					iosf_pkg::PH_LEN: begin
						if (hdr_byte < iosf_pkg::OPT_MIN_LEN ||
								len_minus2 > {1'b0, remaining}) begin
							bad_d = 1'b1;
							stopped_d = 1'b1;
						end else begin
							skip_left_d = len_minus2;
							phase_d = (len_minus2 == '0) ? iosf_pkg::PH_TYPE
								: iosf_pkg::PH_SKIP;
						end
					end
					iosf_pkg::PH_SKIP: begin
						if (skip_left_q <= 8'd1) begin
							skip_left_d = '0;
							phase_d = iosf_pkg::PH_TYPE;
						end else begin
							skip_left_d = skip_left_q - 8'd1;
						end
					end
					default: begin
						phase_d = iosf_pkg::PH_TYPE;
					end
				endcase
			end

			if (is_last) begin
				// A type byte with no length byte left overruns the header
				if (protocol_hit_d && !stopped_d && phase_d == iosf_pkg::PH_LEN) begin
					bad_d = 1'b1;
				end
				verdict_done_d = 1'b1;
				res_valid = 1'b1;
				res.drop = protocol_hit_d && found_d && !bad_d;
				res.malformed = protocol_hit_d && bad_d;
				res.matched_type = protocol_hit_d ? found_type_d : '0;
			end else if (byte_count_q < iosf_pkg::COUNT_MAX) begin
				byte_count_d = byte_count_q + 6'd1;
			end
		end
	end

	// Advance the parse state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			header_bytes_q <= '0;
			protocol_hit_q <= 1'b0;
			phase_q <= iosf_pkg::PH_TYPE;
			skip_left_q <= '0;
			found_q <= 1'b0;
			stopped_q <= 1'b0;
			bad_q <= 1'b0;
			found_type_q <= '0;
			verdict_done_q <= 1'b1;
		end else if (step_en) begin
			byte_count_q <= byte_count_d;
			header_bytes_q <= header_bytes_d;
			protocol_hit_q <= protocol_hit_d;
			phase_q <= phase_d;
			skip_left_q <= skip_left_d;
			found_q <= found_d;
			stopped_q <= stopped_d;
			bad_q <= bad_d;
			found_type_q <= found_type_d;
			verdict_done_q <= verdict_done_d;
		end
	end

	// Skip phase always has bytes left to skip
	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == iosf_pkg::PH_SKIP |-> skip_left_q != '0)
		else $error("skip phase with nothing left to skip");

	// A verdict closes the packet
	a_verdict_closes: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid |=> verdict_done_q)
		else $error("packet still open after its verdict");

	// A short header never stays open
	a_short_header: assert property (@(posedge clk) disable iff (!arst_n)
		header_bytes_q < iosf_pkg::OPTIONS_POS |-> verdict_done_q)
		else $error("short header left open");

	// Malformed headers are never dropped
	a_drop_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.drop && res.malformed))
		else $error("drop and malformed together");

endmodule

// ===== src/ip_option_security_filter_top.sv =====
// IPv4 header option filter: top level.
// Header bytes come in on in_ch, one per transfer, in wire order; start_of_packet
// marks byte 0. For packets whose protocol byte equals the filtered protocol the
// option bytes after byte 19 are walked, and on the last header byte one verdict
// (drop, malformed, matched_type) goes out on out_ch. Bytes after a verdict and
// before the next start mark give nothing; an early start mark abandons a packet.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while the block is idle, which the block itself does not enforce.
// Index 0 and 1 hold the two security option types, index 2 the protocol.
// Throughput is one byte per cycle while out_ch does not stall: each byte is
// registered, then parsed by the per-byte state update into the result register.
// Reset clears the pipeline and parse state and loads the registers with 130, 133
// and 6; the block then waits for a start mark.
// When out_ch stalls with a verdict held, the input register still takes one
// more byte and then holds; in_ch.ready drops only while both stages are full.
module ip_option_security_filter_top (
	input  logic clk,
	input  logic arst_n,
	iosf_in_if.sink in_ch,
	iosf_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [iosf_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [iosf_pkg::ByteW-1:0] cfg_wdata
);

	iosf_pkg::cfg_t cfg_q;
	logic valid_s1;
	logic [iosf_pkg::ByteW-1:0] byte_s1;
	logic sop_s1;
	logic out_valid_q;
	iosf_pkg::result_t result_q;
	logic advance;
	logic step_en;
	logic res_valid;
	iosf_pkg::result_t res;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_sec_type <= iosf_pkg::RST_FIRST_SEC_TYPE;
			cfg_q.second_sec_type <= iosf_pkg::RST_SECOND_SEC_TYPE;
			cfg_q.filtered_protocol <= iosf_pkg::RST_FILTERED_PROTOCOL;
		end else if (cfg_we) begin
			case (cfg_index)
				iosf_pkg::CFG_FIRST_SEC_TYPE: cfg_q.first_sec_type <= cfg_wdata;
				iosf_pkg::CFG_SECOND_SEC_TYPE: cfg_q.second_sec_type <= cfg_wdata;
				iosf_pkg::CFG_FILTERED_PROTOCOL: cfg_q.filtered_protocol <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Stage 1 moves on whenever the result register is free or being emptied
	assign advance = !out_valid_q || out_ch.ready;
	assign step_en = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	// Hold the accepted byte in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.hdr_byte;
			sop_s1 <= in_ch.start_of_packet;
		end
	end

	iosf_parser u_parser (
		.clk (clk),
		.arst_n (arst_n),
		.step_en (step_en),
		.hdr_byte (byte_s1),
		.start_of_packet (sop_s1),
		.cfg (cfg_q),
		.res_valid (res_valid),
		.res (res)
	);

	// Result register: load a verdict, drop it once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_en && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_valid) begin
			result_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.drop = result_q.drop;
	assign out_ch.malformed = result_q.malformed;
	assign out_ch.matched_type = result_q.matched_type;

endmodule

// ===== tb/iosf_verdict_checker.sv =====
// Verdict checker for the IPv4 header option filter: watches both channels, predicts, compares.
`timescale 1ns / 1ps
module iosf_verdict_checker
	import iosf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	iosf_in_if in_ch,
	iosf_out_if out_ch,
	input  logic cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0] cfg_wdata,
	output int unsigned fail_count,
	output int unsigned verdicts_pending
);

	// Shadow copy of the registers and of the per-packet parse state
	cfg_t regs;
	logic [CountW-1:0] byte_pos;
	logic [CountW-1:0] hdr_len;
	logic proto_match;
	phase_t opt_phase;
	logic [ByteW-1:0] skip_cnt;
	logic sec_seen;
	logic walk_done;
	logic len_bad;
	logic [ByteW-1:0] sec_type;
	logic awaiting_sop;

	// Verdicts due from the block, oldest first
	result_t verdict_q[$];

	task automatic report_mismatch(input string msg);
		// keep the log bounded on a badly broken build
		if (fail_count < 100)
			$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic clear_pkt();
		byte_pos = '0;
		hdr_len = '0;
		proto_match = 1'b0;
		opt_phase = PH_TYPE;
		skip_cnt = '0;
		sec_seen = 1'b0;
		walk_done = 1'b0;
		len_bad = 1'b0;
		sec_type = '0;
	endtask

	// Advance the option walk by one byte at header position idx
	task automatic walk_option(input logic [ByteW-1:0] b, input logic [CountW-1:0] idx);
		int room;
		room = int'(hdr_len) - 1 - int'(idx);
		case (opt_phase)
			PH_TYPE: begin
				if (b == OPT_END) begin
					walk_done = 1'b1;
				end else if (b != OPT_NOP) begin
					// only the first security type seen is kept
					if ((b == regs.first_sec_type || b == regs.second_sec_type) && !sec_seen) begin
						sec_seen = 1'b1;
						sec_type = b;
					end
					opt_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				// length below two, or skip running past the header end
				if (b < OPT_MIN_LEN || int'(b) - 2 > room) begin
					len_bad = 1'b1;
					walk_done = 1'b1;
				end else begin
					skip_cnt = b - OPT_MIN_LEN;
					opt_phase = (skip_cnt == 0) ? PH_TYPE : PH_SKIP;
				end
			end
			default: begin
				if (skip_cnt != 0)
					skip_cnt--;
				if (skip_cnt == 0)
					opt_phase = PH_TYPE;
			end
		endcase
	endtask

	// Work out the verdict, if any, caused by one accepted header byte
	task automatic predict_byte(input logic [ByteW-1:0] b, input logic sop);
		logic [CountW-1:0] idx;
		result_t v;
		if (sop) begin
			clear_pkt();
			awaiting_sop = 1'b0;
			hdr_len = {b[3:0], 2'b00};
			if (b[3:0] < MIN_IHL) begin
				// short header: malformed verdict straight away
				awaiting_sop = 1'b1;
				v.drop = 1'b0;
				v.malformed = 1'b1;
				v.matched_type = '0;
				verdict_q.push_back(v);
			end else begin
				byte_pos = 6'd1;
			end
			return;
		end
		// drop stray bytes between a verdict and the next start mark
		if (awaiting_sop)
			return;
		idx = byte_pos;
		if (idx == PROTOCOL_POS)
			proto_match = (b == regs.filtered_protocol);
		if (idx >= OPTIONS_POS && proto_match && !walk_done)
			walk_option(b, idx);
		if (int'(idx) + 1 >= int'(hdr_len)) begin
			// type byte on the last position leaves the length missing
			if (proto_match && !walk_done && opt_phase == PH_LEN)
				len_bad = 1'b1;
			v.drop = proto_match && sec_seen && !len_bad;
			v.malformed = proto_match && len_bad;
			v.matched_type = proto_match ? sec_type : '0;
			verdict_q.push_back(v);
			awaiting_sop = 1'b1;
		end else if (byte_pos < COUNT_MAX) begin
			byte_pos++;
		end
	endtask

	// Compare one verdict transfer with the oldest prediction
	task automatic check_verdict();
		result_t exp_v;
		if (verdict_q.size() == 0) begin
			report_mismatch($sformatf("verdict drop=%0b malformed=%0b type=%0d with none due",
				out_ch.drop, out_ch.malformed, out_ch.matched_type));
			return;
		end
		exp_v = verdict_q.pop_front();
		if (out_ch.drop !== exp_v.drop)
			report_mismatch($sformatf("drop expected %0b got %b", exp_v.drop, out_ch.drop));
		if (out_ch.malformed !== exp_v.malformed)
			report_mismatch($sformatf("malformed expected %0b got %b",
				exp_v.malformed, out_ch.malformed));
		if (out_ch.matched_type !== exp_v.matched_type)
			report_mismatch($sformatf("matched_type expected %0d got %0d",
				exp_v.matched_type, out_ch.matched_type));
	endtask

	// Sample every transfer and register write at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = {RST_FIRST_SEC_TYPE, RST_SECOND_SEC_TYPE, RST_FILTERED_PROTOCOL};
			clear_pkt();
			awaiting_sop = 1'b1;
			verdict_q.delete();
			fail_count = 0;
			verdicts_pending = 0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_verdict();
			if (cfg_we) begin
				case (cfg_index)
					CFG_FIRST_SEC_TYPE: regs.first_sec_type = cfg_wdata;
					CFG_SECOND_SEC_TYPE: regs.second_sec_type = cfg_wdata;
					CFG_FILTERED_PROTOCOL: regs.filtered_protocol = cfg_wdata;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				predict_byte(in_ch.hdr_byte, in_ch.start_of_packet);
			verdicts_pending = verdict_q.size();
		end
	end

endmodule

// ===== tb/tb_ip_option_security_filter_top.sv =====
// Testbench top for the IPv4 header option filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_ip_option_security_filter_top;
	import iosf_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [ByteW-1:0] cfg_wdata;
	int unsigned fail_count;
	int unsigned verdicts_pending;

	// Register values currently in the block, used to aim the stimulus
	cfg_t cur_cfg;
	// High while both sides run without idling
	logic calm;
	// Header under construction
	logic [ByteW-1:0] hdr_q[$];

	iosf_in_if in_ch ();
	iosf_out_if out_ch ();

	ip_option_security_filter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	iosf_verdict_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.verdicts_pending(verdicts_pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Stall the verdict channel at random
	initial begin
		int n;
		int g;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			out_ch.ready = 1'b1;
			n = $urandom_range(1, 12);
			repeat (n) @(negedge clk);
			g = gap_len();
			if (g > 0) begin
				out_ch.ready = 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	end

	// Offer one byte, after a random gap, and hold until the transfer
	task automatic push_byte(input logic [ByteW-1:0] b, input logic sop);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.hdr_byte = b;
		in_ch.start_of_packet = sop;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Send the first n bytes of the header under construction
	task automatic send_header(input int n);
		for (int i = 0; i < n; i++)
			push_byte(hdr_q[i], i == 0);
	endtask

	// Build a header with four given option bytes, zeros after them
	task automatic fill_fixed(input int ihl, input logic [ByteW-1:0] proto,
			input logic [ByteW-1:0] o0, input logic [ByteW-1:0] o1,
			input logic [ByteW-1:0] o2, input logic [ByteW-1:0] o3);
		hdr_q.delete();
		hdr_q.push_back({4'h4, 4'(ihl)});
		for (int i = 1; i < 20; i++)
			hdr_q.push_back((i == PROTOCOL_POS) ? proto : 8'($urandom));
		hdr_q.push_back(o0);
		hdr_q.push_back(o1);
		hdr_q.push_back(o2);
		hdr_q.push_back(o3);
		while (hdr_q.size() < ihl * 4)
			hdr_q.push_back('0);
	endtask

	// Build a random header: mostly small, options mostly well formed
	task automatic make_header();
		int r;
		int ihl;
		int opt_len;
		int pos;
		int len;
		int top_len;
		logic stopped;
		logic [ByteW-1:0] t;
		hdr_q.delete();
		r = $urandom_range(0, 99);
		ihl = (r < 70) ? $urandom_range(5, 7) : (r < 90) ? $urandom_range(8, 11) :
			$urandom_range(12, 15);
		hdr_q.push_back({4'($urandom), 4'(ihl)});
		for (int i = 1; i < 20; i++) begin
			if (i == PROTOCOL_POS && $urandom_range(0, 99) < 85)
				hdr_q.push_back(cur_cfg.filtered_protocol);
			else
				hdr_q.push_back(8'($urandom));
		end
		opt_len = ihl * 4 - 20;
		pos = 0;
		stopped = 1'b0;
		while (pos < opt_len && !stopped) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				hdr_q.push_back(OPT_NOP);
				pos++;
			end else if (r < 20) begin
				hdr_q.push_back(OPT_END);
				pos++;
				stopped = 1'b1;
			end else begin
				if (r < 45)
					t = $urandom_range(0, 1) ? cur_cfg.first_sec_type : cur_cfg.second_sec_type;
				else
					t = 8'($urandom_range(2, 255));
				hdr_q.push_back(t);
				pos++;
				if (pos < opt_len) begin
					if (r < 90) begin
						// length that fits in what is left of the header
						top_len = opt_len - pos + 1;
						len = $urandom_range(2, (top_len < 12) ? top_len : 12);
						hdr_q.push_back(8'(len));
						pos++;
						repeat (len - 2) hdr_q.push_back(8'($urandom));
						pos += len - 2;
					end else begin
						// length below two or running past the header end
						if ($urandom_range(0, 1))
							hdr_q.push_back(8'($urandom_range(0, 1)));
						else
							hdr_q.push_back(8'($urandom_range(opt_len - pos + 2, 255)));
						pos++;
						stopped = 1'b1;
					end
				end
			end
		end
		while (hdr_q.size() < ihl * 4)
			hdr_q.push_back(8'($urandom));
	endtask

	// Random traffic until both goals are met
	task automatic run_traffic(input int byte_goal, input int pkt_goal);
		int bytes;
		int pkts;
		int r;
		int n;
		bytes = 0;
		pkts = 0;
		while (bytes < byte_goal || pkts < pkt_goal) begin
			if ($urandom_range(0, 9) == 0)
				calm = ~calm;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				// short header length
				push_byte({4'($urandom), 4'($urandom_range(0, 4))}, 1'b1);
				bytes++;
				pkts++;
			end else if (r < 80) begin
				make_header();
				send_header(hdr_q.size());
				bytes += hdr_q.size();
				pkts++;
			end else if (r < 88) begin
				// cut the header short
				make_header();
				n = $urandom_range(1, hdr_q.size() - 1);
				send_header(n);
				bytes += n;
			end else if (r < 94) begin
				n = $urandom_range(1, 4);
				repeat (n) push_byte(8'($urandom), 1'b0);
			end else begin
				push_byte(8'($urandom), $urandom_range(0, 3) == 0);
				bytes++;
			end
		end
	endtask

	// Hold the input idle until every verdict is out and the pipeline has drained
	task automatic settle();
		in_ch.valid = 1'b0;
		while (verdicts_pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second,
			input logic [ByteW-1:0] proto);
		write_reg(CFG_FIRST_SEC_TYPE, first);
		write_reg(CFG_SECOND_SEC_TYPE, second);
		write_reg(CFG_FILTERED_PROTOCOL, proto);
		cfg_we = 1'b0;
		cur_cfg = {first, second, proto};
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FIRST_SEC_TYPE;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.hdr_byte = '0;
		in_ch.start_of_packet = 1'b0;
		calm = 1'b0;
		cur_cfg = {RST_FIRST_SEC_TYPE, RST_SECOND_SEC_TYPE, RST_FILTERED_PROTOCOL};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Short headers, then stray bytes after the verdict
		push_byte(8'h00, 1'b1);
		push_byte(8'hF4, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		// Security option found
		fill_fixed(6, RST_FILTERED_PROTOCOL, RST_FIRST_SEC_TYPE, 8'd4, 8'hAA, 8'h55);
		send_header(hdr_q.size());
		// Pad, second security type, end of list
		fill_fixed(6, RST_FILTERED_PROTOCOL, OPT_NOP, RST_SECOND_SEC_TYPE, 8'd2, OPT_END);
		send_header(hdr_q.size());
		// Option length below two
		fill_fixed(6, RST_FILTERED_PROTOCOL, 8'd7, 8'd1, 8'd0, 8'd0);
		send_header(hdr_q.size());
		// Option running past the header end
		fill_fixed(6, RST_FILTERED_PROTOCOL, 8'd7, 8'd9, 8'd0, 8'd0);
		send_header(hdr_q.size());
		// Security type on the last byte: malformed but still named
		fill_fixed(6, RST_FILTERED_PROTOCOL, 8'd68, 8'd2, OPT_NOP, RST_FIRST_SEC_TYPE);
		send_header(hdr_q.size());
		// Other protocol: no walk
		fill_fixed(6, 8'd17, RST_FIRST_SEC_TYPE, 8'd4, 8'd0, 8'd0);
		send_header(hdr_q.size());
		// Early start mark abandons the packet
		fill_fixed(6, RST_FILTERED_PROTOCOL, RST_FIRST_SEC_TYPE, 8'd4, 8'd0, 8'd0);
		send_header(12);
		// Largest header with one option spanning all of it
		fill_fixed(15, RST_FILTERED_PROTOCOL, 8'hFF, 8'd40, 8'hFF, 8'hFF);
		send_header(hdr_q.size());

		run_traffic(140, 4);
		settle();
		set_config(8'd0, 8'd255, 8'd0);
		run_traffic(140, 4);
		settle();
		set_config(8'd255, 8'd0, 8'd255);
		run_traffic(140, 4);
		settle();
		set_config(8'($urandom), 8'($urandom), 8'($urandom));
		run_traffic(140, 4);

		// Drain and give the verdict
		in_ch.valid = 1'b0;
		while (verdicts_pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
